// ===== hdl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the 24-bit BMP stream encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;
  localparam int   CFG_DATA_W       = 13;

  // channel scaling, Q3.12 input
  localparam logic signed [15:0] Q_ONE    = 16'sd4096;
  localparam logic        [7:0]  CH_MAX   = 8'd255;
  localparam logic        [19:0] CH_SCALE = 20'd255;

  // header layout (byte offsets into the 54-byte header)
  localparam int         HDR_BYTES  = 54;
  localparam logic [5:0] HDR_LAST   = 6'(HDR_BYTES - 1);
  localparam logic [5:0] OFS_SIG    = 6'd0;
  localparam logic [5:0] OFS_FSIZE  = 6'd2;
  localparam logic [5:0] OFS_DOFS   = 6'd10;
  localparam logic [5:0] OFS_ISIZE  = 6'd14;
  localparam logic [5:0] OFS_WIDTH  = 6'd18;
  localparam logic [5:0] OFS_HEIGHT = 6'd22;
  localparam logic [5:0] OFS_PLANES = 6'd26;
  localparam logic [5:0] OFS_BPP    = 6'd28;
  localparam logic [5:0] OFS_DSIZE  = 6'd34;
  localparam logic [5:0] OFS_XPPM   = 6'd38;
  localparam logic [5:0] OFS_YPPM   = 6'd42;

  localparam logic [7:0] SIG_B     = 8'h42;
  localparam logic [7:0] SIG_M     = 8'h4D;
  localparam logic [7:0] INFO_SIZE = 8'd40;
  localparam logic [7:0] BPP_24    = 8'd24;
  localparam logic [7:0] PPM_LO    = 8'h13;
  localparam logic [7:0] PPM_HI    = 8'h0B;
  localparam logic [7:0] PLANES    = 8'd1;

  // pixel byte positions
  localparam logic [5:0] PIX_BLUE  = 6'd0;
  localparam logic [5:0] PIX_GREEN = 6'd1;
  localparam logic [5:0] PIX_LAST  = 6'd2;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_HDR,
    SER_PIX,
    SER_PAD
  } ser_state_t;

  // one pixel with its framing info, handed from the lanes to the merger
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       hdr;
    logic [1:0] pad;
    logic       img_end;
  } pix_item_t;

  function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    b = v[8*k +: 8];
    return b;
  endfunction

endpackage

// ===== hdl/bse_lane.sv =====
// ----------------------------------------------------------------------------
// bse_lane
// One channel lane: clamps a Q3.12 level to [0,1] and scales it to a byte.
// ----------------------------------------------------------------------------
module bse_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] level,
  output logic        [7:0]  byte_r
);

  logic [19:0] prod;
  logic [7:0]  byte_nxt;

  always_comb begin
    prod = 20'(level[11:0]) * bse_pkg::CH_SCALE;
    if (level <= 16'sd0) begin
      byte_nxt = 8'd0;
    end else if (level >= bse_pkg::Q_ONE) begin
      byte_nxt = bse_pkg::CH_MAX;
    end else begin
      byte_nxt = prod[19:12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ===== hdl/bse_hdr_gen.sv =====
// ----------------------------------------------------------------------------
// bse_hdr_gen
// BMP header byte generator; sizes are recomputed in registers from the
// effective width and height.
// ----------------------------------------------------------------------------
module bse_hdr_gen #(
  parameter int SIDE_W = 13
) (
  input  logic              clk,
  input  logic [SIDE_W-1:0] eff_w,
  input  logic [SIDE_W-1:0] eff_h,
  input  logic [5:0]        idx,
  output logic [7:0]        hdr_byte
);

  logic [SIDE_W+1:0] row_bytes_r, row_bytes_nxt;
  logic [31:0]       data_size_r, data_size_nxt;
  logic [31:0]       file_size;
  logic [31:0]       w32, h32;

  // row length is 3w rounded up to 4, and the pad equals w mod 4
  assign row_bytes_nxt = (SIDE_W+2)'(eff_w) * (SIDE_W+2)'(3) + (SIDE_W+2)'(2'(eff_w));
  assign data_size_nxt = 32'(32'(eff_h) * 32'(row_bytes_r));
  assign file_size     = data_size_r + 32'(bse_pkg::HDR_BYTES);
  assign w32           = 32'(eff_w);
  assign h32           = 32'(eff_h);

  always_ff @(posedge clk) begin
    row_bytes_r <= row_bytes_nxt;
    data_size_r <= data_size_nxt;
  end

  always_comb begin
    case (idx) inside
      bse_pkg::OFS_SIG:
        hdr_byte = bse_pkg::SIG_B;
      bse_pkg::OFS_SIG + 6'd1:
        hdr_byte = bse_pkg::SIG_M;
      [bse_pkg::OFS_FSIZE : bse_pkg::OFS_FSIZE + 6'd3]:
        hdr_byte = bse_pkg::le_byte(file_size, 2'(idx - bse_pkg::OFS_FSIZE));
      bse_pkg::OFS_DOFS:
        hdr_byte = 8'(bse_pkg::HDR_BYTES);
      bse_pkg::OFS_ISIZE:
        hdr_byte = bse_pkg::INFO_SIZE;
      [bse_pkg::OFS_WIDTH : bse_pkg::OFS_WIDTH + 6'd3]:
        hdr_byte = bse_pkg::le_byte(w32, 2'(idx - bse_pkg::OFS_WIDTH));
      [bse_pkg::OFS_HEIGHT : bse_pkg::OFS_HEIGHT + 6'd3]:
        hdr_byte = bse_pkg::le_byte(h32, 2'(idx - bse_pkg::OFS_HEIGHT));
      bse_pkg::OFS_PLANES:
        hdr_byte = bse_pkg::PLANES;
      bse_pkg::OFS_BPP:
        hdr_byte = bse_pkg::BPP_24;
      [bse_pkg::OFS_DSIZE : bse_pkg::OFS_DSIZE + 6'd3]:
        hdr_byte = bse_pkg::le_byte(data_size_r, 2'(idx - bse_pkg::OFS_DSIZE));
      bse_pkg::OFS_XPPM, bse_pkg::OFS_YPPM:
        hdr_byte = bse_pkg::PPM_LO;
      bse_pkg::OFS_XPPM + 6'd1, bse_pkg::OFS_YPPM + 6'd1:
        hdr_byte = bse_pkg::PPM_HI;
      default:
        hdr_byte = 8'd0;
    endcase
  end

endmodule

// ===== hdl/bse_merge.sv =====
// ----------------------------------------------------------------------------
// bse_merge
// Merges the lane bytes with header and padding into one byte stream and
// drives the output register.
// ----------------------------------------------------------------------------
module bse_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                a_valid,
  input  bse_pkg::pix_item_t  a_item,
  output logic                a_take,
  output logic [5:0]          hdr_idx,
  input  logic [7:0]          hdr_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_eoi
);

  bse_pkg::ser_state_t state_r, state_nxt;
  logic [5:0]          pos_r, pos_nxt;
  bse_pkg::pix_item_t  cur_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_eoi_r;

  logic       out_adv;
  logic       emit;
  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;

  assign out_adv = !out_valid_r || !out_stall;
  assign hdr_idx = pos_r;

  // output decode
  always_comb begin
    emit     = (state_r != bse_pkg::SER_IDLE) && out_adv;
    byte_sel = 8'd0;
    last_sel = 1'b0;
    case (state_r)
      bse_pkg::SER_HDR: begin
        byte_sel = hdr_byte;
      end
      bse_pkg::SER_PIX: begin
        case (pos_r)
          bse_pkg::PIX_BLUE:  byte_sel = cur_r.blue;
          bse_pkg::PIX_GREEN: byte_sel = cur_r.green;
          default:            byte_sel = cur_r.red;
        endcase
        last_sel = (pos_r == bse_pkg::PIX_LAST) && (cur_r.pad == 2'd0);
      end
      bse_pkg::SER_PAD: begin
        last_sel = (2'(pos_r) == cur_r.pad - 2'd1);
      end
      default: begin
        byte_sel = 8'd0;
      end
    endcase
    load   = a_valid && ((state_r == bse_pkg::SER_IDLE) || (emit && last_sel));
    a_take = load;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (load) begin
      state_nxt = a_item.hdr ? bse_pkg::SER_HDR : bse_pkg::SER_PIX;
      pos_nxt   = 6'd0;
    end else if (emit) begin
      case (state_r)
        bse_pkg::SER_HDR: begin
          if (pos_r == bse_pkg::HDR_LAST) begin
            state_nxt = bse_pkg::SER_PIX;
            pos_nxt   = 6'd0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        bse_pkg::SER_PIX: begin
          if (pos_r == bse_pkg::PIX_LAST) begin
            state_nxt = (cur_r.pad == 2'd0) ? bse_pkg::SER_IDLE : bse_pkg::SER_PAD;
            pos_nxt   = 6'd0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        bse_pkg::SER_PAD: begin
          if (last_sel) begin
            state_nxt = bse_pkg::SER_IDLE;
            pos_nxt   = 6'd0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        default: begin
          state_nxt = bse_pkg::SER_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bse_pkg::SER_IDLE;
      pos_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (out_adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= a_item;
    end
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
      out_eoi_r  <= last_sel && cur_r.img_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_eoi   = out_eoi_r;

endmodule

// ===== hdl/bmp24_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// bmp24_stream_encoder_top
// Streaming 24-bit uncompressed BMP writer: one RGB pixel in, its bytes out.
// ----------------------------------------------------------------------------
// path: the first byte of an accepted pixel passes the lane register, then the
//   merger load, then the output register
// output: 3 bytes per pixel, plus the 54 header bytes for the first pixel of a
//   frame and the pad bytes (width mod 4) at each row end; the single output
//   register sends one byte per cycle while out_stall is low
// reset: synchronous active-low; clears the pipeline and the row/column
//   counters, and sets width and height to 1
// ----------------------------------------------------------------------------
module bmp24_stream_encoder_top #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 in_red_level,
  input  logic signed [15:0]                 in_green_level,
  input  logic signed [15:0]                 in_blue_level,
  // byte items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte_out,
  output logic                               out_last_of_run,
  output logic                               out_end_of_image,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // effective side width holds MAX_SIDE itself, counters hold MAX_SIDE-1
  localparam int EW = $clog2(MAX_SIDE + 1);
  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam logic [16:0] MaxSide17 = 17'(MAX_SIDE);

  // a zero side acts as 1, an oversized side as MAX_SIDE
  function automatic logic [EW-1:0] eff_side(input logic [bse_pkg::CFG_DATA_W-1:0] v);
    logic [16:0] v17;
    logic [16:0] e17;
    v17 = 17'(v);
    if (v17 == 17'd0) begin
      e17 = 17'd1;
    end else if (v17 > MaxSide17) begin
      e17 = MaxSide17;
    end else begin
      e17 = v17;
    end
    return EW'(e17);
  endfunction

  // configuration registers, always ready
  logic [bse_pkg::CFG_DATA_W-1:0] width_r, height_r;
  logic                           cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bse_pkg::CFG_DATA_W'(1);
      height_r <= bse_pkg::CFG_DATA_W'(1);
    end else if (cfg_fire) begin
      case (cfg_index)
        bse_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        bse_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_w, eff_h;
  assign eff_w = eff_side(width_r);
  assign eff_h = eff_side(height_r);

  // raster position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [EW:0]   col_inc, row_inc;
  logic          hdr_c, row_end_c, img_end_c;

  logic in_fire;
  logic a_take;

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    col_inc   = (EW+1)'(col_r) + (EW+1)'(1);
    row_inc   = (EW+1)'(row_r) + (EW+1)'(1);
    hdr_c     = (col_r == '0) && (row_r == '0);
    // a column at or past the last one ends the row (covers a mid-frame resize)
    row_end_c = (col_inc >= (EW+1)'(eff_w));
    img_end_c = row_end_c && (row_inc >= (EW+1)'(eff_h));
    col_nxt   = row_end_c ? '0 : CW'(col_inc);
    if (!row_end_c) begin
      row_nxt = row_r;
    end else if (img_end_c) begin
      row_nxt = '0;
    end else begin
      row_nxt = CW'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // lane stage: three channel lanes side by side, plus framing flags
  logic       a_valid_r;
  logic       a_hdr_r;
  logic [1:0] a_pad_r;
  logic       a_img_end_r;
  logic [7:0] lane_red, lane_green, lane_blue;

  bse_lane u_lane_red (
    .clk    (clk),
    .en     (in_fire),
    .level  (in_red_level),
    .byte_r (lane_red)
  );

  bse_lane u_lane_green (
    .clk    (clk),
    .en     (in_fire),
    .level  (in_green_level),
    .byte_r (lane_green)
  );

  bse_lane u_lane_blue (
    .clk    (clk),
    .en     (in_fire),
    .level  (in_blue_level),
    .byte_r (lane_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_hdr_r     <= hdr_c;
      // padding only at row end; pad equals width mod 4
      a_pad_r     <= row_end_c ? 2'(eff_w) : 2'd0;
      a_img_end_r <= img_end_c;
    end
  end

  // lane stage accepts a new item whenever it is empty or its contents move on this cycle
  assign in_stall = a_valid_r && !a_take;

  bse_pkg::pix_item_t a_item;
  always_comb begin
    a_item.blue    = lane_blue;
    a_item.green   = lane_green;
    a_item.red     = lane_red;
    a_item.hdr     = a_hdr_r;
    a_item.pad     = a_pad_r;
    a_item.img_end = a_img_end_r;
  end

  // header bytes, looked up by the merger's position
  logic [5:0] hdr_idx;
  logic [7:0] hdr_byte;

  bse_hdr_gen #(
    .SIDE_W (EW)
  ) u_hdr_gen (
    .clk      (clk),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .idx      (hdr_idx),
    .hdr_byte (hdr_byte)
  );

  // merging stage: header, lane bytes in blue/green/red order, row padding
  bse_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid_r),
    .a_item    (a_item),
    .a_take    (a_take),
    .hdr_idx   (hdr_idx),
    .hdr_byte  (hdr_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte_out),
    .out_last  (out_last_of_run),
    .out_eoi   (out_end_of_image)
  );

  // checks
  a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_image |-> out_last_of_run)
    else $error("end of image without end of item");

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    a_take |-> a_valid_r)
    else $error("merger took an item from an empty lane stage");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && img_end_c |=> (col_r == '0) && (row_r == '0))
    else $error("counters not cleared after last pixel of image");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_out))
    else $error("stalled output byte changed");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 24-bit BMP stream encoder: pixels go in under
// random gaps and back-pressure, and every byte that comes out is compared
// with a bit-exact software encoder kept in step with the accepted pixels.
// ----------------------------------------------------------------------------
module tb;

  localparam int SIDE_CAP    = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  // one expected byte of the file stream
  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       eoi;
  } bmp_byte_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [15:0]             in_red_level;
  logic signed [15:0]             in_green_level;
  logic signed [15:0]             in_blue_level;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_byte_out;
  logic                           out_last_of_run;
  logic                           out_end_of_image;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data;

  // encoder shadow state
  logic [bse_pkg::CFG_DATA_W-1:0] width_reg;
  logic [bse_pkg::CFG_DATA_W-1:0] height_reg;
  int unsigned                    col_pos;
  int unsigned                    row_pos;

  bmp_byte_t   pending_bytes[$];
  bmp_byte_t   next_want;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  bmp24_stream_encoder_top #(.MAX_SIDE(SIDE_CAP)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_image (out_end_of_image),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // software encoder
  // ---------------------------------------------------------------------------

  // size register as the block sees it: 0 reads as 1, anything past the cap
  // is clipped to the cap
  function automatic int unsigned side_eff(input logic [bse_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIDE_CAP) return SIDE_CAP;
    return v;
  endfunction

  // clamp q3.12 to [0,1], scale by 255, truncate
  function automatic logic [7:0] level_to_byte(input logic signed [15:0] v);
    int unsigned p;
    if (v <= 0) return 8'd0;
    if (v >= 16'sd4096) return 8'd255;
    p = int'(v) * 255;
    return p[19:12];
  endfunction

  task automatic push_byte(input logic [7:0] v);
    bmp_byte_t e;
    e.value = v;
    e.last  = 1'b0;
    e.eoi   = 1'b0;
    pending_bytes.push_back(e);
  endtask

  // 14-byte file header then 40-byte info header, multi-byte fields little endian
  task automatic push_header(input int unsigned w, input int unsigned h,
                             input int unsigned pad);
    logic [7:0]  hdr [bse_pkg::HDR_BYTES];
    logic [63:0] data_sz;
    logic [31:0] file_sz;
    logic [31:0] w32;
    logic [31:0] h32;
    data_sz = 64'(h) * (64'(w) * 3 + 64'(pad));
    file_sz = data_sz[31:0] + 32'd54;
    w32     = w;
    h32     = h;
    foreach (hdr[i]) hdr[i] = 8'h00;
    hdr[0]  = 8'h42;  // 'B'
    hdr[1]  = 8'h4D;  // 'M'
    for (int k = 0; k < 4; k++) begin
      hdr[2 + k]  = file_sz[8*k +: 8];
      hdr[18 + k] = w32[8*k +: 8];
      hdr[22 + k] = h32[8*k +: 8];
      hdr[34 + k] = data_sz[8*k +: 8];
    end
    hdr[10] = 8'd54;  // pixel data offset
    hdr[14] = 8'd40;  // info header size
    hdr[26] = 8'd1;   // planes
    hdr[28] = 8'd24;  // bits per pixel
    // 72 dpi in pixels per metre, both axes
    hdr[38] = 8'h13;
    hdr[39] = 8'h0B;
    hdr[42] = 8'h13;
    hdr[43] = 8'h0B;
    foreach (hdr[i]) push_byte(hdr[i]);
  endtask

  // expected bytes for one accepted pixel
  task automatic encode_pixel(input logic signed [15:0] r, input logic signed [15:0] g,
                              input logic signed [15:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned pad;
    logic        img_end;
    bmp_byte_t   tail;
    w       = side_eff(width_reg);
    h       = side_eff(height_reg);
    pad     = (4 - (w * 3) % 4) % 4;
    img_end = 1'b0;
    if (col_pos == 0 && row_pos == 0) push_header(w, h, pad);
    push_byte(level_to_byte(b));
    push_byte(level_to_byte(g));
    push_byte(level_to_byte(r));
    // counters are compared with >= so a size cut mid-frame still closes it
    if (col_pos + 1 >= w) begin
      repeat (pad) push_byte(8'h00);
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        img_end = 1'b1;
        row_pos = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    tail = pending_bytes.pop_back();
    tail.last = 1'b1;
    tail.eoi  = img_end;
    pending_bytes.push_back(tail);
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // random idle gaps ahead of the item, then hold it until accepted
  task automatic send_pixel(input logic signed [15:0] r, input logic signed [15:0] g,
                            input logic signed [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_red_level   = r;
    in_green_level = g;
    in_blue_level  = b;
    do @(posedge clk); while (in_stall);
    encode_pixel(r, g, b);
  endtask

  // drop the pixel bus and let every predicted byte come back; the extra
  // cycles cover bytes still inside the pipeline
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [bse_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bse_pkg::CFG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_size(input logic [bse_pkg::CFG_DATA_W-1:0] w,
                          input logic [bse_pkg::CFG_DATA_W-1:0] h);
    wait_drained();
    write_reg(bse_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(bse_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // mix of full-range noise, in-range levels and clamp edges
  function automatic logic signed [15:0] rand_level();
    logic signed [15:0] edges [8];
    edges = '{16'sd0, 16'sd1, -16'sd1, 16'sd4095, 16'sd4096, 16'sd4097,
              16'sh7FFF, 16'sh8000};
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return edges[$urandom_range(7)];
      default: return 16'($urandom_range(4096));
    endcase
  endfunction

  task automatic send_random_pixel();
    send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset sizes, clamp edges, every pad length, zero and oversized sizes,
  // and a size change in the middle of a frame
  task automatic test_directed();
    // reset size 1x1: header, one pixel, one pad byte
    send_pixel(16'sh7FFF, 16'sh8000, 16'sd4096);
    // 3x2, pad 3
    set_size(13'd3, 13'd2);
    send_pixel(16'sd4095, 16'sd1, -16'sd1);
    send_pixel(16'sd0, 16'sd4097, 16'sd2048);
    send_pixel(16'sd4096, 16'sd4096, 16'sd4096);
    send_pixel(16'sh8000, 16'sh7FFF, 16'sd17);
    send_pixel(16'sd16, 16'sd15, 16'sd3000);
    send_pixel(-16'sd4096, 16'sd1024, 16'shFFFF);
    // zero sizes behave as 1x1
    set_size(13'd0, 13'd0);
    send_pixel(16'sd100, 16'sd200, 16'sd300);
    send_pixel(16'sd4096, 16'sd0, 16'sd4096);
    // 2x3, pad 2
    set_size(13'd2, 13'd3);
    repeat (6) send_random_pixel();
    // oversized width, largest height: header shows the cap
    set_size(13'h1FFF, 13'd4096);
    send_pixel(16'sd1, 16'sd2, 16'sd3);
    // largest width, oversized height, mid-frame
    set_size(13'd4096, 13'h1FFF);
    send_pixel(16'sd4, 16'sd5, 16'sd6);
    // shrink to 4x1 mid-frame, the fourth pixel closes the row and the frame
    set_size(13'd4, 13'd1);
    send_pixel(16'sd7, 16'sd8, 16'sd9);
    send_pixel(16'sd10, 16'sd11, 16'sd12);
    wait_drained();
  endtask

  // random image shapes with full and partial frames
  task automatic test_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int unsigned sent;
    int unsigned n_px;
    int unsigned sel;
    logic [bse_pkg::CFG_DATA_W-1:0] w;
    logic [bse_pkg::CFG_DATA_W-1:0] h;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        // huge or clipped sizes: a few pixels only, frame left open
        w = 13'($urandom_range(4000, 8191));
        h = 13'($urandom);
      end else if (sel == 1) begin
        w = 13'($urandom_range(2));
        h = 13'($urandom_range(2));
      end else begin
        w = 13'($urandom_range(1, 9));
        h = 13'($urandom_range(1, 4));
      end
      set_size(w, h);
      if (sel == 0) n_px = $urandom_range(1, 3);
      else n_px = $urandom_range(1, side_eff(w) * side_eff(h) + 2);
      if (n_px > n_items - sent) n_px = n_items - sent;
      repeat (n_px) send_random_pixel();
      sent += n_px;
    end
    wait_drained();
  endtask

  // receiver holds off while pixels keep coming, so the block backs up
  task automatic test_backpressure();
    set_size(13'd7, 13'd6);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    repeat (25) send_random_pixel();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall, result check, watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual %02h", $time, out_byte_out);
      end else begin
        next_want = pending_bytes.pop_front();
        if (out_byte_out !== next_want.value) begin
          errors++;
          $display("%0t: byte_out expected %02h actual %02h", $time, next_want.value,
                   out_byte_out);
        end
        if (out_last_of_run !== next_want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b actual %0b", $time, next_want.last,
                   out_last_of_run);
        end
        if (out_end_of_image !== next_want.eoi) begin
          errors++;
          $display("%0t: end_of_image expected %0b actual %0b", $time, next_want.eoi,
                   out_end_of_image);
        end
      end
    end
  end

  // a hang shows up here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_red_level   = '0;
    in_green_level = '0;
    in_blue_level  = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = bse_pkg::CFG_IMAGE_WIDTH;
    cfg_data       = '0;
    width_reg      = 13'd1;
    height_reg     = 13'd1;
    col_pos        = 0;
    row_pos        = 0;
    errors         = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(55, 0, 0);
    test_random_phase(55, 57, 0);
    test_random_phase(55, 0, 57);
    test_random_phase(55, 38, 38);
    test_backpressure();

    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== bmp24_stream_encoder_top.f =====
hdl/bse_pkg.sv
hdl/bse_lane.sv
hdl/bse_hdr_gen.sv
hdl/bse_merge.sv
hdl/bmp24_stream_encoder_top.sv
bench/tb.sv
